// ===== sv/lavm_pkg.sv =====
package lavm_pkg;

    localparam int FRAC_BITS = 16;

    // Widths of the fixed-point values along the datapath.
    localparam int IN_W     = 32;
    localparam int DIFF_W   = IN_W + 1;
    localparam int QW       = FRAC_BITS + 1;
    localparam int ZW       = FRAC_BITS + 2;
    localparam int PW       = IN_W + ZW;
    localparam int NW       = PW + 1;
    localparam int SHW      = $clog2(NW);
    localparam int MAG_W    = 30;
    localparam int MAG_TOP  = MAG_W - 1;
    localparam int SUM_W    = 2 * MAG_W + 2;
    localparam int SQ_STEPS = SUM_W / 2;
    localparam int LEN_W    = SQ_STEPS;
    localparam int REM_W    = LEN_W + 1;
    localparam int NUM_W    = MAG_W + FRAC_BITS + 1;
    localparam int ZZW      = 2 * ZW;
    localparam int DW       = PW + 2;
    localparam int YW       = FRAC_BITS + 5;
    localparam int PYW      = IN_W + YW;
    localparam int DYW      = PYW + 2;

    // Register stages of one normalizer: abs, max, shift search, shift,
    // squares, sum plus root steps, quotient setup plus quotient steps, sign.
    localparam int NORM_LAT = 5 + (SQ_STEPS + 1) + (QW + 1) + 1;

    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic valid;
        logic ok;
    } lavm_stat_t;

    // floor((v + half) / 2^FRAC_BITS)
    function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
        return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== sv/look_at_view_matrix_core.sv =====
// Column 0 of a matrix, with 16 fractional bits, reaches the result ports through both
// normalizers and the product stages; columns 1 to 3 follow back to back.
// A new matrix is taken only while busy is low; busy rises after each start transfer
// and paces the intake to the four result transfers per item.
// The two vector normalizers are fully pipelined (root and quotient one bit per stage).
// Reset clears the valid bits and the output sequencer; no result is lost to a stall.
module look_at_view_matrix_core
    import lavm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,
    output logic               result_valid,
    output logic [1:0]         column_index,
    output logic signed [31:0] entry_0,
    output logic signed [31:0] entry_1,
    output logic signed [31:0] entry_2,
    output logic signed [31:0] entry_3,
    output logic               final_column,
    output logic               degenerate
);

    logic [1:0]               cnt_reg;
    logic                     accept;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [IN_W-1:0]   eye1_reg [3];
    logic signed [IN_W-1:0]   up1_reg  [3];
    logic signed [DIFF_W-1:0] d1_reg   [3];
    logic signed [NW-1:0]     na_in    [3];

    lavm_stat_t               stat_a, stat_b;
    logic signed [ZW-1:0]     z_a [3];
    logic signed [ZW-1:0]     x_b [3];

    logic signed [IN_W-1:0]   eye_da_reg [NORM_LAT][3];
    logic signed [IN_W-1:0]   up_da_reg  [NORM_LAT][3];

    logic signed [PW-1:0]     pu2_reg [6];
    logic signed [IN_W-1:0]   eye2_reg [3];
    logic signed [ZW-1:0]     z2_reg  [3];
    logic                     okz2_reg;

    logic signed [NW-1:0]     cr3_reg [3];
    logic signed [IN_W-1:0]   eye3_reg [3];
    logic signed [ZW-1:0]     z3_reg  [3];
    logic                     okz3_reg;

    logic signed [IN_W-1:0]   eye_db_reg [NORM_LAT][3];
    logic signed [ZW-1:0]     z_db_reg   [NORM_LAT][3];
    logic                     okz_db_reg [NORM_LAT];

    logic signed [ZZW-1:0]    pzx4_reg [6];
    logic signed [PW-1:0]     pex4_reg [3];
    logic signed [PW-1:0]     pez4_reg [3];
    logic signed [IN_W-1:0]   eye4_reg [3];
    logic signed [ZW-1:0]     x4_reg  [3];
    logic signed [ZW-1:0]     z4_reg  [3];
    logic                     ok4_reg;

    logic signed [YW-1:0]     y5_reg [3];
    logic signed [DW-1:0]     sx5_reg, sz5_reg;
    logic signed [IN_W-1:0]   eye5_reg [3];
    logic signed [ZW-1:0]     x5_reg [3];
    logic signed [ZW-1:0]     z5_reg [3];
    logic                     ok5_reg;
    logic signed [63:0]       y5_next [3];

    logic signed [PYW-1:0]    pey6_reg [3];
    logic signed [31:0]       tx6_reg, tz6_reg;
    logic signed [YW-1:0]     y6_reg [3];
    logic signed [ZW-1:0]     x6_reg [3];
    logic signed [ZW-1:0]     z6_reg [3];
    logic                     ok6_reg;

    logic signed [DYW-1:0]    sy7_reg;
    logic signed [31:0]       tx7_reg, tz7_reg;
    logic signed [YW-1:0]     y7_reg [3];
    logic signed [ZW-1:0]     x7_reg [3];
    logic signed [ZW-1:0]     z7_reg [3];
    logic                     ok7_reg;

    logic signed [31:0]       mat_reg [4][4];
    logic signed [31:0]       mat_next [4][4];
    logic                     deg_reg;

    logic                     emit_on_reg;
    logic [1:0]               emit_col_reg;
    logic                     rv_reg, fc_reg, dg_reg;
    logic [1:0]               ci_reg;
    logic signed [31:0]       e_reg [4];

    assign accept = start && !busy;
    assign busy   = (cnt_reg != 2'd0);

    // Control state: intake spacing, stage valid bits, result sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= 2'd0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            emit_on_reg  <= 1'b0;
            emit_col_reg <= 2'd0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
                cnt_reg <= 2'd3;
            else if (cnt_reg != 2'd0)
                cnt_reg <= cnt_reg - 2'd1;
            v1_reg <= accept;
            v2_reg <= stat_a.valid;
            v3_reg <= v2_reg;
            v4_reg <= stat_b.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            rv_reg <= emit_on_reg;
            if (v7_reg)
            begin
                emit_on_reg  <= 1'b1;
                emit_col_reg <= 2'd0;
            end
            else if (emit_on_reg)
            begin
                emit_col_reg <= emit_col_reg + 2'd1;
                if (emit_col_reg == 2'd3)
                    emit_on_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        eye1_reg[0] <= eye_x;
        eye1_reg[1] <= eye_y;
        eye1_reg[2] <= eye_z;
        up1_reg[0]  <= up_x;
        up1_reg[1]  <= up_y;
        up1_reg[2]  <= up_z;
        d1_reg[0]   <= DIFF_W'(eye_x) - DIFF_W'(target_x);
        d1_reg[1]   <= DIFF_W'(eye_y) - DIFF_W'(target_y);
        d1_reg[2]   <= DIFF_W'(eye_z) - DIFF_W'(target_z);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            na_in[i] = NW'(d1_reg[i]);
    end

    lavm_norm u_norm_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v1_reg),
        .v        (na_in),
        .stat     (stat_a),
        .u        (z_a)
    );

    // Eye and up wait alongside the view-axis normalizer.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye_da_reg[0][i] <= eye1_reg[i];
            up_da_reg[0][i]  <= up1_reg[i];
            for (int k = 1; k < NORM_LAT; k++)
            begin
                eye_da_reg[k][i] <= eye_da_reg[k-1][i];
                up_da_reg[k][i]  <= up_da_reg[k-1][i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pu2_reg[0] <= PW'(up_da_reg[NORM_LAT-1][1]) * PW'(z_a[2]);
        pu2_reg[1] <= PW'(up_da_reg[NORM_LAT-1][2]) * PW'(z_a[1]);
        pu2_reg[2] <= PW'(up_da_reg[NORM_LAT-1][2]) * PW'(z_a[0]);
        pu2_reg[3] <= PW'(up_da_reg[NORM_LAT-1][0]) * PW'(z_a[2]);
        pu2_reg[4] <= PW'(up_da_reg[NORM_LAT-1][0]) * PW'(z_a[1]);
        pu2_reg[5] <= PW'(up_da_reg[NORM_LAT-1][1]) * PW'(z_a[0]);
        okz2_reg   <= stat_a.ok;
        okz3_reg   <= okz2_reg;
        for (int i = 0; i < 3; i++)
        begin
            eye2_reg[i] <= eye_da_reg[NORM_LAT-1][i];
            z2_reg[i]   <= z_a[i];
            eye3_reg[i] <= eye2_reg[i];
            z3_reg[i]   <= z2_reg[i];
            cr3_reg[i]  <= NW'(pu2_reg[2*i]) - NW'(pu2_reg[2*i+1]);
        end
    end

    lavm_norm u_norm_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v3_reg),
        .v        (cr3_reg),
        .stat     (stat_b),
        .u        (x_b)
    );

    always_ff @(posedge clk)
    begin
        okz_db_reg[0] <= okz3_reg;
        for (int k = 1; k < NORM_LAT; k++)
            okz_db_reg[k] <= okz_db_reg[k-1];
        for (int i = 0; i < 3; i++)
        begin
            eye_db_reg[0][i] <= eye3_reg[i];
            z_db_reg[0][i]   <= z3_reg[i];
            for (int k = 1; k < NORM_LAT; k++)
            begin
                eye_db_reg[k][i] <= eye_db_reg[k-1][i];
                z_db_reg[k][i]   <= z_db_reg[k-1][i];
            end
        end
    end

    // y = z cross x and the eye dot products.
    always_ff @(posedge clk)
    begin
        pzx4_reg[0] <= ZZW'(z_db_reg[NORM_LAT-1][1]) * ZZW'(x_b[2]);
        pzx4_reg[1] <= ZZW'(z_db_reg[NORM_LAT-1][2]) * ZZW'(x_b[1]);
        pzx4_reg[2] <= ZZW'(z_db_reg[NORM_LAT-1][2]) * ZZW'(x_b[0]);
        pzx4_reg[3] <= ZZW'(z_db_reg[NORM_LAT-1][0]) * ZZW'(x_b[2]);
        pzx4_reg[4] <= ZZW'(z_db_reg[NORM_LAT-1][0]) * ZZW'(x_b[1]);
        pzx4_reg[5] <= ZZW'(z_db_reg[NORM_LAT-1][1]) * ZZW'(x_b[0]);
        ok4_reg     <= okz_db_reg[NORM_LAT-1] && stat_b.ok;
        for (int i = 0; i < 3; i++)
        begin
            pex4_reg[i] <= PW'(eye_db_reg[NORM_LAT-1][i]) * PW'(x_b[i]);
            pez4_reg[i] <= PW'(eye_db_reg[NORM_LAT-1][i]) * PW'(z_db_reg[NORM_LAT-1][i]);
            eye4_reg[i] <= eye_db_reg[NORM_LAT-1][i];
            x4_reg[i]   <= x_b[i];
            z4_reg[i]   <= z_db_reg[NORM_LAT-1][i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            y5_next[i] = rnd_frac(64'(pzx4_reg[2*i]) - 64'(pzx4_reg[2*i+1]));
    end

    always_ff @(posedge clk)
    begin
        sx5_reg <= DW'(pex4_reg[0]) + DW'(pex4_reg[1]) + DW'(pex4_reg[2]);
        sz5_reg <= DW'(pez4_reg[0]) + DW'(pez4_reg[1]) + DW'(pez4_reg[2]);
        ok5_reg <= ok4_reg;
        tx6_reg <= sat32(rnd_frac(-64'(sx5_reg)));
        tz6_reg <= sat32(rnd_frac(-64'(sz5_reg)));
        ok6_reg <= ok5_reg;
        sy7_reg <= DYW'(pey6_reg[0]) + DYW'(pey6_reg[1]) + DYW'(pey6_reg[2]);
        tx7_reg <= tx6_reg;
        tz7_reg <= tz6_reg;
        ok7_reg <= ok6_reg;
        for (int i = 0; i < 3; i++)
        begin
            y5_reg[i]   <= y5_next[i][YW-1:0];
            eye5_reg[i] <= eye4_reg[i];
            x5_reg[i]   <= x4_reg[i];
            z5_reg[i]   <= z4_reg[i];
            pey6_reg[i] <= PYW'(eye5_reg[i]) * PYW'(y5_reg[i]);
            y6_reg[i]   <= y5_reg[i];
            x6_reg[i]   <= x5_reg[i];
            z6_reg[i]   <= z5_reg[i];
            y7_reg[i]   <= y6_reg[i];
            x7_reg[i]   <= x6_reg[i];
            z7_reg[i]   <= z6_reg[i];
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mat_next[c][0] = 32'(x7_reg[c]);
            mat_next[c][1] = 32'(y7_reg[c]);
            mat_next[c][2] = 32'(z7_reg[c]);
            mat_next[c][3] = '0;
        end
        mat_next[3][0] = tx7_reg;
        mat_next[3][1] = sat32(rnd_frac(-64'(sy7_reg)));
        mat_next[3][2] = tz7_reg;
        mat_next[3][3] = ONE_FX;
        if (!ok7_reg)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    mat_next[c][r] = '0;
        end
    end

    // The matrix is held until its fourth column has been transferred;
    // the next one can only arrive on that same edge.
    always_ff @(posedge clk)
    begin
        if (v7_reg)
        begin
            mat_reg <= mat_next;
            deg_reg <= !ok7_reg;
        end
        ci_reg <= emit_col_reg;
        fc_reg <= (emit_col_reg == 2'd3);
        dg_reg <= deg_reg;
        for (int r = 0; r < 4; r++)
            e_reg[r] <= mat_reg[emit_col_reg][r];
    end

    assign result_valid = rv_reg;
    assign column_index = ci_reg;
    assign entry_0      = e_reg[0];
    assign entry_1      = e_reg[1];
    assign entry_2      = e_reg[2];
    assign entry_3      = e_reg[3];
    assign final_column = fc_reg;
    assign degenerate   = dg_reg;

`ifndef ASSERT_OFF
    a_final_after_three: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && final_column |->
            $past(result_valid, 1) && $past(result_valid, 2) && $past(result_valid, 3))
        else $error("final column without three preceding results");

    a_column_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (column_index != 2'd0) |->
            $past(result_valid) && ($past(column_index) == column_index - 2'd1))
        else $error("result columns out of order");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && degenerate |->
            (entry_0 == 32'sd0) && (entry_1 == 32'sd0) && (entry_2 == 32'sd0)
            && (entry_3 == 32'sd0))
        else $error("degenerate matrix with nonzero entry");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after start transfer");
`endif

endmodule

// ===== sv/lavm_norm.sv =====
module lavm_norm
    import lavm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [NW-1:0] v [3],
    output lavm_stat_t           stat,
    output logic signed [ZW-1:0] u [3]
);

    logic                 vld_reg [NORM_LAT];

    logic [NW-1:0]        mg1_reg [3];
    logic                 neg1_reg [3];
    logic [NW-1:0]        mg1_next [3];

    logic [NW-1:0]        mg2_reg [3];
    logic                 neg2_reg [3];
    logic [NW-1:0]        m2_reg;
    logic [NW-1:0]        m2_next;

    logic [NW-1:0]        mg3_reg [3];
    logic                 neg3_reg [3];
    logic                 ok3_reg;
    logic                 right3_reg;
    logic [SHW-1:0]       amt3_reg;
    logic [SHW-1:0]       pos;

    logic [MAG_W-1:0]     mg4_reg [3];
    logic                 neg4_reg [3];
    logic                 ok4_reg;
    logic [NW-1:0]        wide4 [3];

    logic [2*MAG_W-1:0]   sq5_reg [3];
    logic [MAG_W-1:0]     mg5_reg [3];
    logic                 neg5_reg [3];
    logic                 ok5_reg;

    // Square root, one result bit per stage; index 0 holds the sum.
    logic [SUM_W-1:0]     sx_reg  [0:SQ_STEPS];
    logic [SUM_W-1:0]     sr_reg  [0:SQ_STEPS];
    logic [MAG_W-1:0]     qmg_reg [0:SQ_STEPS][3];
    logic                 qneg_reg[0:SQ_STEPS][3];
    logic                 qok_reg [0:SQ_STEPS];
    logic [SUM_W-1:0]     sx_next [1:SQ_STEPS];
    logic [SUM_W-1:0]     sr_next [1:SQ_STEPS];

    // Restoring division, one quotient bit per stage; index 0 is the setup.
    logic [REM_W-1:0]     rem_reg [0:QW][3];
    logic [QW-1:0]        dn_reg  [0:QW][3];
    logic [QW-1:0]        dq_reg  [0:QW][3];
    logic [LEN_W-1:0]     dl_reg  [0:QW];
    logic                 dneg_reg[0:QW][3];
    logic                 dok_reg [0:QW];
    logic [REM_W-1:0]     rem_next[1:QW][3];
    logic [QW-1:0]        dq_next [1:QW][3];
    logic [NUM_W-1:0]     num0 [3];
    logic [REM_W-1:0]     trial [1:QW][3];

    logic signed [ZW-1:0] u_reg [3];
    logic                 uok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NORM_LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NORM_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mg1_next[i] = v[i][NW-1] ? NW'(-v[i]) : NW'(v[i]);
        m2_next = mg1_reg[0];
        if (mg1_reg[1] > m2_next)
            m2_next = mg1_reg[1];
        if (mg1_reg[2] > m2_next)
            m2_next = mg1_reg[2];
        pos = '0;
        for (int b = 0; b < NW; b++)
            if (m2_reg[b])
                pos = SHW'(b);
        for (int i = 0; i < 3; i++)
            wide4[i] = right3_reg ? (mg3_reg[i] >> amt3_reg) : (mg3_reg[i] << amt3_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mg1_reg[i]  <= mg1_next[i];
            neg1_reg[i] <= v[i][NW-1];
            mg2_reg[i]  <= mg1_reg[i];
            neg2_reg[i] <= neg1_reg[i];
            mg3_reg[i]  <= mg2_reg[i];
            neg3_reg[i] <= neg2_reg[i];
            mg4_reg[i]  <= wide4[i][MAG_W-1:0];
            neg4_reg[i] <= neg3_reg[i];
            sq5_reg[i]  <= (2*MAG_W)'(mg4_reg[i]) * (2*MAG_W)'(mg4_reg[i]);
            mg5_reg[i]  <= mg4_reg[i];
            neg5_reg[i] <= neg4_reg[i];
        end
        m2_reg     <= m2_next;
        ok3_reg    <= (m2_reg != '0);
        right3_reg <= (pos > SHW'(MAG_TOP));
        amt3_reg   <= (pos > SHW'(MAG_TOP)) ? pos - SHW'(MAG_TOP) : SHW'(MAG_TOP) - pos;
        ok4_reg    <= ok3_reg;
        ok5_reg    <= ok4_reg;
    end

    always_comb
    begin
        for (int k = 1; k <= SQ_STEPS; k++)
        begin
            if (sx_reg[k-1] >= sr_reg[k-1] + (SUM_W'(1) << (2 * (SQ_STEPS - k))))
            begin
                sx_next[k] = sx_reg[k-1] - (sr_reg[k-1] + (SUM_W'(1) << (2 * (SQ_STEPS - k))));
                sr_next[k] = (sr_reg[k-1] >> 1) + (SUM_W'(1) << (2 * (SQ_STEPS - k)));
            end
            else
            begin
                sx_next[k] = sx_reg[k-1];
                sr_next[k] = sr_reg[k-1] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg[0]  <= SUM_W'(sq5_reg[0]) + SUM_W'(sq5_reg[1]) + SUM_W'(sq5_reg[2]);
        sr_reg[0]  <= '0;
        qok_reg[0] <= ok5_reg;
        for (int i = 0; i < 3; i++)
        begin
            qmg_reg[0][i]  <= mg5_reg[i];
            qneg_reg[0][i] <= neg5_reg[i];
        end
        for (int k = 1; k <= SQ_STEPS; k++)
        begin
            sx_reg[k]  <= sx_next[k];
            sr_reg[k]  <= sr_next[k];
            qok_reg[k] <= qok_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                qmg_reg[k][i]  <= qmg_reg[k-1][i];
                qneg_reg[k][i] <= qneg_reg[k-1][i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            num0[i] = {1'b0, qmg_reg[SQ_STEPS][i], {FRAC_BITS{1'b0}}}
                    + NUM_W'(sr_reg[SQ_STEPS][LEN_W-1:1]);
        for (int k = 1; k <= QW; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[k][i]    = {rem_reg[k-1][i][REM_W-2:0], dn_reg[k-1][i][QW-k]};
                dq_next[k][i]  = dq_reg[k-1][i];
                if (trial[k][i] >= {1'b0, dl_reg[k-1]})
                begin
                    rem_next[k][i]        = trial[k][i] - {1'b0, dl_reg[k-1]};
                    dq_next[k][i][QW-k]   = 1'b1;
                end
                else
                    rem_next[k][i] = trial[k][i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg[0]  <= sr_reg[SQ_STEPS][LEN_W-1:0];
        dok_reg[0] <= qok_reg[SQ_STEPS];
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[0][i]  <= REM_W'(num0[i][NUM_W-1:QW]);
            dn_reg[0][i]   <= num0[i][QW-1:0];
            dq_reg[0][i]   <= '0;
            dneg_reg[0][i] <= qneg_reg[SQ_STEPS][i];
        end
        for (int k = 1; k <= QW; k++)
        begin
            dl_reg[k]  <= dl_reg[k-1];
            dok_reg[k] <= dok_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[k][i]  <= rem_next[k][i];
                dn_reg[k][i]   <= dn_reg[k-1][i];
                dq_reg[k][i]   <= dq_next[k][i];
                dneg_reg[k][i] <= dneg_reg[k-1][i];
            end
        end
        for (int i = 0; i < 3; i++)
            u_reg[i] <= dneg_reg[QW][i] ? -$signed({1'b0, dq_reg[QW][i]})
                                        :  $signed({1'b0, dq_reg[QW][i]});
        uok_reg <= dok_reg[QW];
    end

    assign stat.valid = vld_reg[NORM_LAT-1];
    assign stat.ok    = uok_reg;
    assign u          = u_reg;

endmodule
